@@ hw/rtl/meq_pkg.sv @@
package meq_pkg;

  localparam int QUEUE_SLOTS_DEF = 32;

  localparam logic [1:0] CMD_GET        = 2'd0;
  localparam logic [1:0] CMD_PUT        = 2'd1;
  localparam logic [1:0] CMD_PUT_UNIQUE = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         class_mask;
    logic [7:0]         event_class;
    logic [7:0]         event_code;
    logic signed [15:0] event_data;
  } in_beat_t;

  typedef struct packed {
    logic               found;
    logic [7:0]         got_class;
    logic [7:0]         got_code;
    logic signed [15:0] got_data;
    logic               lost;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]         ev_class;
    logic [7:0]         ev_code;
    logic signed [15:0] ev_data;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_UNLINK,
    ST_FREE,
    ST_PUT_RD,
    ST_PUT_WR,
    ST_RESP
  } state_t;

endpackage

@@ hw/rtl/masked_event_queue.sv @@
// Event queue of up to QUEUE_SLOTS-1 events kept as a linked list in a slot
// memory, with a free list and one empty tail slot. A put passes the put read,
// put write and response states before its result beat. A get or put unique
// walks the list from the oldest event at one queued event per cycle (one read
// of the slot and link memories per step); a get that removes the oldest event
// then passes the free state, one that removes a later event the unlink and
// free states, and a put unique that finds no match the put read and put write
// states. One item is processed at a time; the result sits in an output
// register, so a new item is accepted while the previous result beat is still
// stalled. A put into a full queue drops the oldest event and flags lost.
module masked_event_queue #(
  parameter int QUEUE_SLOTS = meq_pkg::QUEUE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  meq_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output meq_pkg::out_beat_t out_data
);
  import meq_pkg::*;

  localparam int IW = $clog2(QUEUE_SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_SLOTS - 1);
  localparam logic [IW:0]   MAX_STEPS = (IW+1)'(QUEUE_SLOTS);

  slot_t         ev_mem [QUEUE_SLOTS];
  logic [IW-1:0] lk_mem [QUEUE_SLOTS];
  logic [QUEUE_SLOTS-1:0] lk_vld_r;

  slot_t         ev_rd_r;
  logic [IW-1:0] lk_rd_r;
  logic [IW-1:0] rd_addr;
  logic          ev_we;
  logic [IW-1:0] ev_wa;
  slot_t         ev_wd;
  logic          lk_we;
  logic [IW-1:0] lk_wa;
  logic [IW-1:0] lk_wd;

  state_t        state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] dummy_r, dummy_nxt;
  logic [IW-1:0] fhead_r, fhead_nxt;
  logic [IW-1:0] fcnt_r, fcnt_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] prev_r, prev_nxt;
  logic [IW-1:0] link_r, link_nxt;
  logic [IW:0]   steps_r, steps_nxt;
  in_beat_t      item_r, item_nxt;
  out_beat_t     res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_beat_t     out_data_r, out_data_nxt;

  logic accept;
  logic is_get;
  logic hit;
  logic walk_end;
  logic out_load;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_get   = (item_r.cmd == CMD_GET);
  assign hit      = is_get ? ((ev_rd_r.ev_class & item_r.class_mask) != 8'd0)
                           : (ev_rd_r.ev_class == item_r.event_class &&
                              ev_rd_r.ev_code  == item_r.event_code  &&
                              ev_rd_r.ev_data  == item_r.event_data);
  assign walk_end = (lk_rd_r == dummy_r) || (steps_r == MAX_STEPS);
  assign out_load = (state_r == ST_RESP) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (ev_we) ev_mem[ev_wa] <= ev_wd;
    ev_rd_r <= ev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (lk_we) lk_mem[lk_wa] <= lk_wd;
    if (lk_vld_r[rd_addr]) begin
      lk_rd_r <= lk_mem[rd_addr];
    end else begin
      lk_rd_r <= (rd_addr == LAST_IDX) ? '0 : rd_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_vld_r <= '0;
    end else if (lk_we) begin
      lk_vld_r[lk_wa] <= 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.cmd == CMD_GET) begin
            state_nxt = (head_r != dummy_r) ? ST_WALK : ST_RESP;
          end else if (in_data.cmd == CMD_PUT_UNIQUE) begin
            state_nxt = (head_r != dummy_r) ? ST_WALK : ST_PUT_RD;
          end else if (in_data.cmd == CMD_PUT) begin
            state_nxt = ST_PUT_RD;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_WALK: begin
        if (hit) begin
          if (is_get) state_nxt = (cur_r == head_r) ? ST_FREE : ST_UNLINK;
          else        state_nxt = ST_RESP;
        end else if (walk_end) begin
          state_nxt = is_get ? ST_RESP : ST_PUT_RD;
        end
      end
      ST_UNLINK: state_nxt = ST_FREE;
      ST_FREE:   state_nxt = ST_RESP;
      ST_PUT_RD: state_nxt = ST_PUT_WR;
      ST_PUT_WR: state_nxt = ST_RESP;
      ST_RESP:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr       = cur_r;
    ev_we         = 1'b0;
    ev_wa         = dummy_r;
    ev_wd         = '{ev_class: item_r.event_class, ev_code: item_r.event_code,
                      ev_data: item_r.event_data};
    lk_we         = 1'b0;
    lk_wa         = cur_r;
    lk_wd         = fhead_r;
    head_nxt      = head_r;
    dummy_nxt     = dummy_r;
    fhead_nxt     = fhead_r;
    fcnt_nxt      = fcnt_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    link_nxt      = link_r;
    steps_nxt     = steps_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt  = in_data;
          res_nxt   = '0;
          rd_addr   = head_r;
          cur_nxt   = head_r;
          prev_nxt  = head_r;
          steps_nxt = (IW+1)'(1);
        end
      end
      ST_WALK: begin
        if (hit) begin
          if (is_get) begin
            res_nxt.found     = 1'b1;
            res_nxt.got_class = ev_rd_r.ev_class;
            res_nxt.got_code  = ev_rd_r.ev_code;
            res_nxt.got_data  = ev_rd_r.ev_data;
            link_nxt          = lk_rd_r;
            if (cur_r == head_r) head_nxt = lk_rd_r;
          end
        end else if (!walk_end) begin
          rd_addr   = lk_rd_r;
          cur_nxt   = lk_rd_r;
          prev_nxt  = cur_r;
          steps_nxt = steps_r + 1'b1;
        end
      end
      ST_UNLINK: begin
        lk_we = 1'b1;
        lk_wa = prev_r;
        lk_wd = link_r;
      end
      ST_FREE: begin
        lk_we     = 1'b1;
        lk_wa     = cur_r;
        lk_wd     = fhead_r;
        fhead_nxt = cur_r;
        if (fcnt_r != LAST_IDX) fcnt_nxt = fcnt_r + 1'b1;
      end
      ST_PUT_RD: begin
        rd_addr = (fcnt_r != '0) ? fhead_r : head_r;
      end
      ST_PUT_WR: begin
        ev_we = 1'b1;
        lk_we = 1'b1;
        lk_wa = dummy_r;
        if (fcnt_r != '0) begin
          lk_wd     = fhead_r;
          dummy_nxt = fhead_r;
          fhead_nxt = lk_rd_r;
          fcnt_nxt  = fcnt_r - 1'b1;
        end else begin
          lk_wd       = head_r;
          dummy_nxt   = head_r;
          head_nxt    = lk_rd_r;
          res_nxt.lost = 1'b1;
        end
      end
      ST_RESP: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      dummy_r     <= '0;
      fhead_r     <= (LAST_IDX == '0) ? '0 : IW'(1);
      fcnt_r      <= LAST_IDX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      dummy_r     <= dummy_nxt;
      fhead_r     <= fhead_nxt;
      fcnt_r      <= fcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    link_r     <= link_nxt;
    steps_r    <= steps_nxt;
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_empty_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ((head_r == dummy_r) == (fcnt_r == LAST_IDX)))
    else $error("queue empty flag disagrees with free count");

  a_load_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESP))
    else $error("result beat loaded outside response state");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (steps_r <= MAX_STEPS && steps_r != '0))
    else $error("list walk out of bounds");

  a_walk_not_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (cur_r != dummy_r))
    else $error("list walk visited the tail slot");

endmodule
